>>> rtl/core/lbrc_pkg.sv
// ----------------------------------------------------------------------------
// lbrc_pkg
// Types and constants shared by the lock bus reply checker.
// ----------------------------------------------------------------------------
package lbrc_pkg;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    // check kinds
    localparam logic [1:0] KIND_OPEN_LOCK = 2'd0;
    localparam logic [1:0] KIND_EEPROM    = 2'd1;
    localparam logic [1:0] KIND_OTHER     = 2'd2;

    // frame constants
    localparam logic [7:0] ERR_START0 = 8'h5D;
    localparam logic [7:0] ERR_START1 = 8'h89;
    localparam logic [7:0] SEQ_MASK   = 8'h07;
    localparam int         SEQ_W      = 3;
    localparam int         FROM_BOARD_BIT = 5;   // 0x20
    localparam int         EXTRA_ACK_BIT  = 4;   // 0x10

    localparam int         CNT_W    = 5;
    localparam int         LEN_W    = CNT_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX  = 5'd31;
    localparam logic [CNT_W-1:0] LONG_LEN = 5'd18;
    localparam logic [LEN_W-1:0] LEN_LONG = 6'd18;
    localparam logic [LEN_W-1:0] LEN_HALF = 6'd9;

    // byte positions within the reply
    localparam logic [CNT_W-1:0] POS_FIRST     = 5'd0;
    localparam logic [CNT_W-1:0] POS_ERR1      = 5'd1;
    localparam logic [CNT_W-1:0] POS_ADDR_LO   = 5'd2;
    localparam logic [CNT_W-1:0] POS_ADDR_HI   = 5'd3;
    localparam logic [CNT_W-1:0] POS_CONTROL   = 5'd4;
    localparam logic [CNT_W-1:0] POS_DATA1     = 5'd5;
    localparam logic [CNT_W-1:0] POS_VAL_HI    = 5'd6;
    localparam logic [CNT_W-1:0] POS_VAL_LO    = 5'd7;
    localparam logic [CNT_W-1:0] POS_CS1       = 5'd8;
    localparam logic [CNT_W-1:0] POS_HALF2     = 5'd9;
    localparam logic [CNT_W-1:0] POS_ADDR_LO2  = 5'd11;
    localparam logic [CNT_W-1:0] POS_CONTROL2  = 5'd13;
    localparam logic [CNT_W-1:0] POS_CS2       = 5'd17;

    // match flag bits
    localparam int MATCH_W     = 7;
    localparam int MF_ADDR_LO  = 0;
    localparam int MF_ADDR_HI  = 1;
    localparam int MF_DATA1    = 2;
    localparam int MF_ADDR_LO2 = 3;
    localparam int MF_CS1      = 4;
    localparam int MF_CS2      = 5;
    localparam int MF_SEQ1     = 6;

    typedef struct packed {
        logic       action;
        logic [1:0] check_kind;
        logic [7:0] cmd_addr_low;
        logic [7:0] cmd_addr_high;
        logic [7:0] cmd_control;
        logic [7:0] cmd_data_one;
        logic [7:0] rx_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        reply_valid;
        logic        error_frame;
        logic        not_reply;
        logic        bad_length;
        logic        bad_control;
        logic        bad_checksum;
        logic        bad_sequence;
        logic        bad_address;
        logic [15:0] eeprom_value;
    } out_item_t;

    // command fields latched on load
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] addr_low;
        logic [7:0] addr_high;
        logic [7:0] control;
        logic [7:0] data_one;
    } expect_t;

    // reply facts gathered byte by byte
    typedef struct packed {
        logic               error_start;
        logic [7:0]         control;
        logic [MATCH_W-1:0] match;
        logic [SEQ_W-1:0]   second_seq;
        logic [15:0]        value_word;
    } reply_state_t;

endpackage

>>> rtl/core/lbrc_chan_if.sv
// ----------------------------------------------------------------------------
// lbrc_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface lbrc_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/lock_bus_response_checker_unit.sv
// ----------------------------------------------------------------------------
// lock_bus_response_checker_unit
// Checks a lock board reply, byte by byte, against the command sent.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready sink. A transfer with action = load latches the
//            command fields and restarts reply collection; a transfer with
//            action = byte feeds one reply byte, in order from byte 0.
//   result : valid/ready source. One transfer per reply byte marked
//            last_byte, carrying the check flags and the EEPROM value.
//   Path   : an item is held in the input register; its result is
//            registered in the result register, which drives
//            result.valid.
//   Throughput: one item per cycle, set by the single state update between
//            the input register and the result register, unless stalled.
//   Reset  : rst_n clears the reply state, the latched command (check kind
//            reads as other) and both valid flags; item.ready is high at once.
//   Stall  : while result is held, items that give no result still move on;
//            an item that would give a result waits in the input register,
//            and item.ready drops only then.
// ----------------------------------------------------------------------------
module lock_bus_response_checker_unit (
    input  logic               clk,
    input  logic               rst_n,
    lbrc_chan_if.sink          item,
    lbrc_chan_if.source        result
);

    lbrc_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    lbrc_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    lbrc_pkg::out_item_t verdict;

    logic gives_result;
    logic out_free;
    logic go;

    // only a final reply byte produces a transfer on result
    assign gives_result = (in_reg.action == lbrc_pkg::ACT_BYTE) && in_reg.last_byte;
    assign out_free     = !out_valid_reg || result.ready;
    assign go           = in_valid_reg && (!gives_result || out_free);

    assign item.ready     = !in_valid_reg || go;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    lbrc_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (go),
        .item_in (in_reg),
        .verdict (verdict)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg <= item.payload;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && gives_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && gives_result)
        begin
            out_reg <= verdict;
        end
    end

endmodule

>>> rtl/core/lbrc_verdict.sv
// ----------------------------------------------------------------------------
// lbrc_verdict
// Combines the gathered reply facts into the result flags.
// ----------------------------------------------------------------------------
module lbrc_verdict (
    input  lbrc_pkg::expect_t      expect_fields,
    input  lbrc_pkg::reply_state_t reply,
    input  logic [lbrc_pkg::LEN_W-1:0] len,
    output lbrc_pkg::out_item_t    verdict
);

    logic ack;
    logic len_ok;
    logic is_rep;
    logic ctl_ok;
    logic cs_ok;
    logic seq_ok;
    logic addr_ok;
    logic valid;
    logic [lbrc_pkg::SEQ_W-1:0] exp_seq;

    always_comb
    begin
        exp_seq = expect_fields.control[lbrc_pkg::SEQ_W-1:0];
        ack     = reply.control[lbrc_pkg::EXTRA_ACK_BIT];
        len_ok  = ack ? (len == lbrc_pkg::LEN_LONG) : (len == lbrc_pkg::LEN_HALF);
        is_rep  = reply.control[lbrc_pkg::FROM_BOARD_BIT];
        ctl_ok  = |(reply.control & expect_fields.control);
        cs_ok   = reply.match[lbrc_pkg::MF_CS1]
                  && (!ack || reply.match[lbrc_pkg::MF_CS2]);
        seq_ok  = reply.match[lbrc_pkg::MF_SEQ1]
                  && (!ack || (reply.second_seq == exp_seq));

        case (expect_fields.kind)
            lbrc_pkg::KIND_OPEN_LOCK:
            begin
                addr_ok = reply.match[lbrc_pkg::MF_ADDR_LO]
                          && reply.match[lbrc_pkg::MF_ADDR_HI]
                          && (!ack || reply.match[lbrc_pkg::MF_ADDR_LO2]);
            end
            lbrc_pkg::KIND_EEPROM:
            begin
                addr_ok = reply.match[lbrc_pkg::MF_ADDR_LO]
                          && reply.match[lbrc_pkg::MF_ADDR_HI]
                          && reply.match[lbrc_pkg::MF_DATA1];
            end
            default:
            begin
                addr_ok = 1'b1;
            end
        endcase

        valid = is_rep && len_ok && ctl_ok && cs_ok && seq_ok && addr_ok;

        verdict = '0;
        if (reply.error_start)
        begin
            verdict.error_frame = 1'b1;
        end
        else
        begin
            verdict.reply_valid  = valid;
            verdict.not_reply    = !is_rep;
            verdict.bad_length   = !len_ok;
            verdict.bad_control  = !ctl_ok;
            verdict.bad_checksum = len_ok && !cs_ok;
            verdict.bad_sequence = len_ok && !seq_ok;
            verdict.bad_address  = !addr_ok;
            verdict.eeprom_value = (valid && (expect_fields.kind == lbrc_pkg::KIND_EEPROM))
                                   ? reply.value_word : 16'd0;
        end
    end

endmodule

>>> rtl/core/lbrc_tracker.sv
// ----------------------------------------------------------------------------
// lbrc_tracker
// Holds the latched command and the running reply state; folds in one item
// per cycle while fire is high and presents the verdict for a final byte.
// ----------------------------------------------------------------------------
module lbrc_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  lbrc_pkg::in_item_t   item_in,
    output lbrc_pkg::out_item_t  verdict
);

    lbrc_pkg::expect_t      expect_reg;
    lbrc_pkg::reply_state_t reply_reg;
    lbrc_pkg::reply_state_t reply_next;
    logic [lbrc_pkg::CNT_W-1:0] cnt_reg;
    logic [lbrc_pkg::CNT_W-1:0] cnt_next;
    logic [7:0]             first_reg;
    logic [7:0]             first_next;
    logic [7:0]             half_sum_reg;
    logic [7:0]             half_sum_next;
    logic [lbrc_pkg::LEN_W-1:0] len;
    logic [7:0]             b;
    logic                   load;
    logic                   take;

    assign b    = item_in.rx_byte;
    assign load = fire && (item_in.action == lbrc_pkg::ACT_LOAD);
    assign take = fire && (item_in.action == lbrc_pkg::ACT_BYTE);
    assign len  = {1'b0, cnt_reg} + lbrc_pkg::LEN_W'(1);

    // fold the current byte into the reply state
    always_comb
    begin
        reply_next    = reply_reg;
        first_next    = first_reg;
        half_sum_next = half_sum_reg;
        cnt_next      = (cnt_reg == lbrc_pkg::CNT_MAX) ? cnt_reg
                        : cnt_reg + lbrc_pkg::CNT_W'(1);

        if (cnt_reg < lbrc_pkg::LONG_LEN)
        begin
            case (cnt_reg)
                lbrc_pkg::POS_FIRST:
                begin
                    first_next = b;
                end
                lbrc_pkg::POS_ERR1:
                begin
                    reply_next.error_start = (first_reg == lbrc_pkg::ERR_START0)
                                             && (b == lbrc_pkg::ERR_START1);
                end
                lbrc_pkg::POS_ADDR_LO:
                begin
                    if (b == expect_reg.addr_low)
                    begin
                        reply_next.match[lbrc_pkg::MF_ADDR_LO] = 1'b1;
                    end
                end
                lbrc_pkg::POS_ADDR_HI:
                begin
                    if (b == expect_reg.addr_high)
                    begin
                        reply_next.match[lbrc_pkg::MF_ADDR_HI] = 1'b1;
                    end
                end
                lbrc_pkg::POS_CONTROL:
                begin
                    reply_next.control = b;
                    if ((b & lbrc_pkg::SEQ_MASK) == (expect_reg.control & lbrc_pkg::SEQ_MASK))
                    begin
                        reply_next.match[lbrc_pkg::MF_SEQ1] = 1'b1;
                    end
                end
                lbrc_pkg::POS_DATA1:
                begin
                    if (b == expect_reg.data_one)
                    begin
                        reply_next.match[lbrc_pkg::MF_DATA1] = 1'b1;
                    end
                end
                lbrc_pkg::POS_VAL_HI:
                begin
                    reply_next.value_word[15:8] = b;
                end
                lbrc_pkg::POS_VAL_LO:
                begin
                    reply_next.value_word[7:0] = b;
                end
                lbrc_pkg::POS_ADDR_LO2:
                begin
                    if (b == expect_reg.addr_low)
                    begin
                        reply_next.match[lbrc_pkg::MF_ADDR_LO2] = 1'b1;
                    end
                end
                lbrc_pkg::POS_CONTROL2:
                begin
                    reply_next.second_seq = b[lbrc_pkg::SEQ_W-1:0];
                end
                default:
                begin
                end
            endcase

            // per-half checksum: clear at half start, compare at bytes 8 and 17
            if ((cnt_reg == lbrc_pkg::POS_FIRST) || (cnt_reg == lbrc_pkg::POS_HALF2))
            begin
                half_sum_next = 8'd0;
            end
            else if ((cnt_reg == lbrc_pkg::POS_CS1) || (cnt_reg == lbrc_pkg::POS_CS2))
            begin
                if (b == half_sum_reg)
                begin
                    if (cnt_reg == lbrc_pkg::POS_CS1)
                    begin
                        reply_next.match[lbrc_pkg::MF_CS1] = 1'b1;
                    end
                    else
                    begin
                        reply_next.match[lbrc_pkg::MF_CS2] = 1'b1;
                    end
                end
            end
            else
            begin
                half_sum_next = half_sum_reg + b;
            end
        end
    end

    lbrc_verdict u_verdict (
        .expect_fields (expect_reg),
        .reply         (reply_next),
        .len           (len),
        .verdict       (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg      <= '0;
            expect_reg.kind <= lbrc_pkg::KIND_OTHER;
            reply_reg       <= '0;
            cnt_reg         <= '0;
            first_reg       <= '0;
            half_sum_reg    <= '0;
        end
        else if (load || (take && item_in.last_byte))
        begin
            if (load)
            begin
                expect_reg.kind      <= item_in.check_kind;
                expect_reg.addr_low  <= item_in.cmd_addr_low;
                expect_reg.addr_high <= item_in.cmd_addr_high;
                expect_reg.control   <= item_in.cmd_control;
                expect_reg.data_one  <= item_in.cmd_data_one;
            end
            reply_reg    <= '0;
            cnt_reg      <= '0;
            first_reg    <= '0;
            half_sum_reg <= '0;
        end
        else if (take)
        begin
            reply_reg    <= reply_next;
            cnt_reg      <= cnt_next;
            first_reg    <= first_next;
            half_sum_reg <= half_sum_next;
        end
    end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for lock_bus_response_checker_unit. Random command loads and reply
// byte streams are driven. Most replies are well formed, some are spoilt,
// and the rest are error frames, noise or cut short by a load. An
// in-bench model predicts each verdict, and every result transfer is
// checked against it.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lbrc_pkg::*;

    // Spare check kind code; the block treats it like "other"
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int ITEM_TARGET  = 1270;   // directed plus roughly 1250 random
    localparam int CALM_FROM    = 500;    // window with no idling on either side
    localparam int CALM_TO      = 800;
    localparam int STALL_LIMIT  = 1000;   // cycles with no transfer before giving up
    localparam int TAIL_CYCLES  = 8;      // result register plus a margin

    typedef logic [7:0] byte_q_t[$];

    // ------------------------------------------------------------------------
    // Verdict predictor and scoreboard
    // ------------------------------------------------------------------------
    class lock_reply_tracker;

        expect_t            cmd;
        logic [CNT_W-1:0]   byte_cnt;
        logic [7:0]         first_b;
        logic [7:0]         half_sum;
        logic [7:0]         rep_ctl;
        logic               err_start;
        logic [MATCH_W-1:0] flags;
        logic [SEQ_W-1:0]   seq2;
        logic [15:0]        value;
        out_item_t          verdict_q[$];
        int                 failures;
        int                 reports;

        function new();
            failures = 0;
            reports  = 0;
            cmd      = '0;
            cmd.kind = KIND_OTHER;
            clear_reply();
        endfunction

        function void clear_reply();
            byte_cnt  = '0;
            first_b   = '0;
            half_sum  = '0;
            rep_ctl   = '0;
            err_start = 1'b0;
            flags     = '0;
            seq2      = '0;
            value     = '0;
        endfunction

        // One reply byte into the running checks; bytes past 17 are ignored
        function void absorb_byte(logic [7:0] b);
            int pos;
            if (byte_cnt >= LONG_LEN)
                return;
            pos = int'(byte_cnt) % 9;
            case (byte_cnt)
                POS_FIRST:    first_b = b;
                POS_ERR1:     err_start = (first_b == ERR_START0) && (b == ERR_START1);
                POS_ADDR_LO:  if (b == cmd.addr_low) flags[MF_ADDR_LO] = 1'b1;
                POS_ADDR_HI:  if (b == cmd.addr_high) flags[MF_ADDR_HI] = 1'b1;
                POS_CONTROL:
                begin
                    rep_ctl = b;
                    if ((b & SEQ_MASK) == (cmd.control & SEQ_MASK))
                        flags[MF_SEQ1] = 1'b1;
                end
                POS_DATA1:    if (b == cmd.data_one) flags[MF_DATA1] = 1'b1;
                POS_VAL_HI:   value[15:8] = b;
                POS_VAL_LO:   value[7:0] = b;
                POS_ADDR_LO2: if (b == cmd.addr_low) flags[MF_ADDR_LO2] = 1'b1;
                POS_CONTROL2: seq2 = b[SEQ_W-1:0];
                default:      ;
            endcase
            // byte 0 of each half restarts the sum, byte 8 is the checksum
            if (pos == 0)
                half_sum = '0;
            else if (pos < 8)
                half_sum = half_sum + b;
            else if (b == half_sum)
                flags[(byte_cnt < POS_HALF2) ? MF_CS1 : MF_CS2] = 1'b1;
        endfunction

        // Called for every accepted item transfer
        function void note_transfer(in_item_t it);
            logic [LEN_W-1:0] len;
            logic             ack, len_ok, cs_ok, seq_ok, addr_ok, is_rep, ctl_ok, ok;
            out_item_t        v;
            if (it.action == ACT_LOAD)
            begin
                cmd.kind      = it.check_kind;
                cmd.addr_low  = it.cmd_addr_low;
                cmd.addr_high = it.cmd_addr_high;
                cmd.control   = it.cmd_control;
                cmd.data_one  = it.cmd_data_one;
                clear_reply();
                return;
            end
            absorb_byte(it.rx_byte);
            len = {1'b0, byte_cnt} + LEN_W'(1);
            if (byte_cnt != CNT_MAX)
                byte_cnt = byte_cnt + CNT_W'(1);
            if (!it.last_byte)
                return;

            v = '0;
            if (err_start)
            begin
                v.error_frame = 1'b1;
                verdict_q.push_back(v);
                clear_reply();
                return;
            end

            ack    = rep_ctl[EXTRA_ACK_BIT];
            len_ok = ack ? (len == LEN_LONG) : (len == LEN_HALF);
            is_rep = rep_ctl[FROM_BOARD_BIT];
            ctl_ok = |(rep_ctl & cmd.control);
            cs_ok  = flags[MF_CS1];
            seq_ok = flags[MF_SEQ1];
            if (ack)
            begin
                cs_ok  = cs_ok & flags[MF_CS2];
                seq_ok = seq_ok & (seq2 == cmd.control[SEQ_W-1:0]);
            end
            case (cmd.kind)
                KIND_OPEN_LOCK: addr_ok = flags[MF_ADDR_LO] & flags[MF_ADDR_HI]
                                          & (!ack | flags[MF_ADDR_LO2]);
                KIND_EEPROM:    addr_ok = flags[MF_ADDR_LO] & flags[MF_ADDR_HI]
                                          & flags[MF_DATA1];
                default:        addr_ok = 1'b1;
            endcase
            ok = is_rep & len_ok & ctl_ok & cs_ok & seq_ok & addr_ok;

            v.reply_valid  = ok;
            v.not_reply    = !is_rep;
            v.bad_length   = !len_ok;
            v.bad_control  = !ctl_ok;
            v.bad_checksum = len_ok & !cs_ok;
            v.bad_sequence = len_ok & !seq_ok;
            v.bad_address  = !addr_ok;
            v.eeprom_value = (ok && cmd.kind == KIND_EEPROM) ? value : 16'h0000;
            verdict_q.push_back(v);
            clear_reply();
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                failures++;
                if (reports < 40)
                    $error("%s: expected %0h, got %0h", name, want, got);
                reports++;
            end
        endfunction

        // Called for every accepted result transfer
        function void check_verdict(out_item_t got);
            out_item_t want;
            if (verdict_q.size() == 0)
            begin
                failures++;
                if (reports < 40)
                    $error("result transfer with no reply outstanding: %h", got);
                reports++;
                return;
            end
            want = verdict_q.pop_front();
            compare("reply_valid",  want.reply_valid,  got.reply_valid);
            compare("error_frame",  want.error_frame,  got.error_frame);
            compare("not_reply",    want.not_reply,    got.not_reply);
            compare("bad_length",   want.bad_length,   got.bad_length);
            compare("bad_control",  want.bad_control,  got.bad_control);
            compare("bad_checksum", want.bad_checksum, got.bad_checksum);
            compare("bad_sequence", want.bad_sequence, got.bad_sequence);
            compare("bad_address",  want.bad_address,  got.bad_address);
            compare("eeprom_value", want.eeprom_value, got.eeprom_value);
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    lbrc_chan_if #(.payload_t(in_item_t))  item_ch ();
    lbrc_chan_if #(.payload_t(out_item_t)) res_ch ();

    lock_bus_response_checker_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    lock_reply_tracker tracker;
    expect_t           cur_cmd;       // last command loaded, for replies without a reload
    int                items_sent;
    int                stall_cycles;
    bit                calm;          // set: neither side idles

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side back-pressure: ready drops about 30% of cycles outside the calm window
    always @(posedge clk)
    begin
        res_ch.ready <= calm || ($urandom_range(99) >= 30);
    end

    // Monitor: both channels sampled at the edge, before any driver update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                tracker.note_transfer(item_ch.payload);
            if (res_ch.valid && res_ch.ready)
                tracker.check_verdict(res_ch.payload);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Watchdog: a long run of cycles with no transfer at all ends the test
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // One item transfer, with random idle cycles in front of it
    task automatic send_item(input in_item_t it);
        while (!calm && $urandom_range(99) < 30)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Load transfer; unused fields carry junk so that they are seen to be ignored
    task automatic send_load(input expect_t c);
        logic [63:0] junk;
        in_item_t    it;
        junk             = {$urandom, $urandom};
        it               = junk[$bits(in_item_t)-1:0];
        it.action        = ACT_LOAD;
        it.check_kind    = c.kind;
        it.cmd_addr_low  = c.addr_low;
        it.cmd_addr_high = c.addr_high;
        it.cmd_control   = c.control;
        it.cmd_data_one  = c.data_one;
        cur_cmd          = c;
        send_item(it);
    endtask

    // Reply bytes in order; the final one is marked last only if asked
    task automatic send_reply(input byte_q_t q, input bit mark_last);
        logic [63:0] junk;
        in_item_t    it;
        for (int i = 0; i < q.size(); i++)
        begin
            junk         = {$urandom, $urandom};
            it           = junk[$bits(in_item_t)-1:0];
            it.action    = ACT_BYTE;
            it.rx_byte   = q[i];
            it.last_byte = mark_last && (i == q.size() - 1);
            send_item(it);
        end
    endtask

    function automatic expect_t random_cmd();
        expect_t c;
        c.kind      = 2'($urandom_range(3));
        c.addr_low  = 8'($urandom_range(255));
        c.addr_high = 8'($urandom_range(255));
        c.control   = 8'($urandom_range(255));
        c.data_one  = 8'($urandom_range(255));
        return c;
    endfunction

    // A reply that passes every check for command c except, at times, the
    // control overlap (9 or 18 bytes); spoil flips bits in one random byte
    function automatic void build_reply(input expect_t c, input bit long_form,
                                        input bit spoil, output byte_q_t q);
        logic [7:0] r[18];
        int         n;
        int         idx;
        n = long_form ? 18 : 9;
        for (int i = 0; i < 18; i++)
            r[i] = 8'($urandom_range(255));
        if (r[0] == ERR_START0 && r[1] == ERR_START1)
            r[1] = 8'h00;
        r[2] = c.addr_low;
        r[3] = c.addr_high;
        r[4] = (r[4] & 8'hC8) | (c.control & SEQ_MASK);
        r[4][FROM_BOARD_BIT] = 1'b1;
        r[4][EXTRA_ACK_BIT]  = long_form;
        if (c.kind == KIND_EEPROM || $urandom_range(1))
            r[5] = c.data_one;
        r[8] = '0;
        for (int i = 1; i < 8; i++)
            r[8] = r[8] + r[i];
        if (long_form)
        begin
            r[11] = c.addr_low;
            r[13] = (r[13] & ~SEQ_MASK) | (c.control & SEQ_MASK);
            r[17] = '0;
            for (int i = 10; i < 17; i++)
                r[17] = r[17] + r[i];
        end
        if (spoil)
        begin
            idx    = $urandom_range(n - 1);
            r[idx] = r[idx] ^ 8'($urandom_range(1, 255));
        end
        q = {};
        for (int i = 0; i < n; i++)
            q.push_back(r[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        expect_t c;
        byte_q_t q;
        int      pick;
        int      n;

        tracker         = new();
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        calm            = 1'b0;
        items_sent      = 0;
        cur_cmd         = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: clean EEPROM read with extreme address bytes
        c = '{KIND_EEPROM, 8'hFF, 8'h00, 8'hFF, 8'hA5};
        send_load(c);
        build_reply(c, 1'b0, 1'b0, q);
        send_reply(q, 1'b1);

        // Board error frame: two bytes and done
        q = {ERR_START0, ERR_START1};
        send_reply(q, 1'b1);

        // All-zero open-lock command, one-byte reply: short, no control overlap
        c = '{KIND_OPEN_LOCK, 8'h00, 8'h00, 8'h00, 8'h00};
        send_load(c);
        q = {8'hFF};
        send_reply(q, 1'b1);

        // Spare kind behaves as other
        c = '{KIND_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_load(c);
        q = {8'h00};
        send_reply(q, 1'b1);

        // Cut short by a load, then a clean long open-lock reply
        q = {8'h12, 8'h34, 8'h56};
        send_reply(q, 1'b0);
        c = '{KIND_OPEN_LOCK, 8'h3C, 8'hC3, 8'h25, 8'h00};
        send_load(c);
        build_reply(c, 1'b1, 1'b0, q);
        send_reply(q, 1'b1);

        // Random part
        while (items_sent < ITEM_TARGET)
        begin
            calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // fresh command, reply mostly right
                send_load(random_cmd());
                build_reply(cur_cmd, $urandom_range(99) < 40, $urandom_range(99) < 25, q);
                send_reply(q, 1'b1);
            end
            else if (pick < 70)
            begin
                // same command again; sequencing across replies
                build_reply(cur_cmd, 1'($urandom_range(1)), $urandom_range(99) < 25, q);
                send_reply(q, 1'b1);
            end
            else if (pick < 78)
            begin
                // error frame with trailing rubbish
                q = {ERR_START0, ERR_START1};
                n = $urandom_range(20);
                for (int i = 0; i < n; i++)
                    q.push_back(8'($urandom_range(255)));
                send_reply(q, 1'b1);
            end
            else if (pick < 88)
            begin
                // noise, long enough to saturate the byte count at times
                q = {};
                n = $urandom_range(1, 36);
                for (int i = 0; i < n; i++)
                    q.push_back(8'($urandom_range(255)));
                send_reply(q, 1'b1);
            end
            else if (pick < 95)
            begin
                // partial reply overtaken by a load
                build_reply(cur_cmd, 1'($urandom_range(1)), 1'b0, q);
                n = $urandom_range(1, q.size() - 1);
                q = q[0:n-1];
                send_reply(q, 1'b0);
                send_load(random_cmd());
            end
            else
            begin
                send_load(random_cmd());
            end
        end
        calm = 1'b0;

        // Drain: let the final transfer reach the tracker, then wait for results
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.verdict_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.failures == 0 && tracker.verdict_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
